// ----- design/alt_pkg.sv -----
// Shared types, constants and helpers for the array list table.
package alt_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_BITS  = 32;
  localparam int DATA_BITS  = 32;
  localparam int KIND_BITS  = 3;
  localparam int INDEX_BITS = 4;
  localparam int COUNT_BITS = 5;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_APPEND = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_REMOVE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_INS,
    S_INS_PUT,
    S_REM_HEAD,
    S_REM
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]  data;
    status_t               status;
    logic [COUNT_BITS-1:0] count;
  } res_t;

  // Sign-extend a stored word and keep the low data bits.
  function automatic logic [DATA_BITS-1:0] widen_word(input logic [WORD_BITS-1:0] w);
    logic signed [63:0] x;
    x = 64'(signed'(w));
    return x[DATA_BITS-1:0];
  endfunction

endpackage

// ----- design/alt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module alt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/alt_ctrl.sv -----
// Request sequencer: decodes requests, moves entries through the RAM, keeps the count.
module alt_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [alt_pkg::KIND_BITS-1:0]    in_kind,
  input  logic [alt_pkg::INDEX_BITS-1:0]   in_index,
  input  logic [alt_pkg::DATA_BITS-1:0]    in_value,
  input  logic                             res_ready,
  output alt_pkg::ram_req_t                ram_req,
  input  logic [alt_pkg::WORD_BITS-1:0]    ram_rdata,
  output logic                             res_valid,
  output alt_pkg::res_t                    res
);
  import alt_pkg::*;

  state_t               state_r, state_nxt;
  logic [ADDR_BITS-1:0] ptr_r, ptr_nxt;
  logic [ADDR_BITS-1:0] pos_r, pos_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [DATA_BITS-1:0] data_r, data_nxt;
  logic [CNT_BITS-1:0]  length_r, length_nxt;

  logic                 in_accept;
  logic [31:0]          idx32;
  logic [ADDR_BITS-1:0] idx_a;
  logic                 in_range;
  logic                 full;
  logic                 more;
  logic [WORD_BITS-1:0] word_in;
  logic [CNT_BITS-1:0]  len_inc;
  logic [CNT_BITS-1:0]  len_dec;
  kind_t                kind;

  assign in_stall  = !((state_r == S_IDLE) && res_ready);
  assign in_accept = in_valid && !in_stall;
  assign kind      = kind_t'(in_kind);
  assign idx32     = 32'(in_index);
  assign idx_a     = idx32[ADDR_BITS-1:0];
  assign in_range  = idx32 < 32'(length_r);
  assign full      = length_r >= CNT_BITS'(DEPTH);
  assign word_in   = WORD_BITS'(in_value);
  assign len_inc   = length_r + CNT_BITS'(1);
  assign len_dec   = length_r - CNT_BITS'(1);
  // another entry above ptr still has to move down
  assign more      = (CNT_BITS'(ptr_r) + CNT_BITS'(1)) < length_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_range) begin
          unique case (kind)
            KIND_READ:   state_nxt = S_RD;
            KIND_INSERT: state_nxt = full ? S_IDLE : S_INS;
            KIND_REMOVE: state_nxt = S_REM_HEAD;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:       state_nxt = S_IDLE;
      S_INS:      state_nxt = (ptr_r == pos_r) ? S_INS_PUT : S_INS;
      S_INS_PUT:  state_nxt = S_IDLE;
      S_REM_HEAD: state_nxt = more ? S_REM : S_IDLE;
      S_REM:      state_nxt = more ? S_REM : S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = ptr_r + ADDR_BITS'(1);
    ram_req.wdata = ram_rdata;
    ram_req.re    = 1'b0;
    ram_req.raddr = ptr_r - ADDR_BITS'(1);
    res_valid     = 1'b0;
    res.data      = '0;
    res.status    = ST_DONE;
    res.count     = COUNT_BITS'(length_r);
    length_nxt    = length_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    data_nxt      = data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          pos_nxt  = idx_a;
          word_nxt = word_in;
          unique case (kind)
            KIND_READ: begin
              if (in_range) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = idx_a;
              end else begin
                res_valid  = 1'b1;
                res.status = ST_RANGE;
              end
            end
            KIND_WRITE: begin
              res_valid = 1'b1;
              if (in_range) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_a;
                ram_req.wdata = word_in;
              end else begin
                res.status = ST_RANGE;
              end
            end
            KIND_APPEND: begin
              res_valid = 1'b1;
              if (full) begin
                res.status = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = length_r[ADDR_BITS-1:0];
                ram_req.wdata = word_in;
                length_nxt    = len_inc;
                res.count     = COUNT_BITS'(len_inc);
              end
            end
            KIND_INSERT: begin
              if (!in_range) begin
                res_valid  = 1'b1;
                res.status = ST_RANGE;
              end else if (full) begin
                res_valid  = 1'b1;
                res.status = ST_FULL;
              end else begin
                // start from the last entry and walk down
                ram_req.re    = 1'b1;
                ram_req.raddr = len_dec[ADDR_BITS-1:0];
                ptr_nxt       = len_dec[ADDR_BITS-1:0];
              end
            end
            KIND_REMOVE: begin
              if (in_range) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = idx_a;
                ptr_nxt       = idx_a;
              end else begin
                res_valid  = 1'b1;
                res.status = ST_RANGE;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        res_valid = 1'b1;
        res.data  = widen_word(ram_rdata);
      end
      S_INS: begin
        // move entry ptr up one place, fetch the one below
        ram_req.we = 1'b1;
        if (ptr_r != pos_r) begin
          ram_req.re = 1'b1;
          ptr_nxt    = ptr_r - ADDR_BITS'(1);
        end
      end
      S_INS_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        ram_req.wdata = word_r;
        length_nxt    = len_inc;
        res_valid     = 1'b1;
        res.count     = COUNT_BITS'(len_inc);
      end
      S_REM_HEAD: begin
        data_nxt = widen_word(ram_rdata);
        if (more) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_r + ADDR_BITS'(1);
          ptr_nxt       = ptr_r + ADDR_BITS'(1);
        end else begin
          length_nxt = len_dec;
          res_valid  = 1'b1;
          res.data   = widen_word(ram_rdata);
          res.count  = COUNT_BITS'(len_dec);
        end
      end
      S_REM: begin
        // move entry ptr down one place
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_r - ADDR_BITS'(1);
        if (more) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_r + ADDR_BITS'(1);
          ptr_nxt       = ptr_r + ADDR_BITS'(1);
        end else begin
          length_nxt = len_dec;
          res_valid  = 1'b1;
          res.data   = data_r;
          res.count  = COUNT_BITS'(len_dec);
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      length_r <= '0;
    end else begin
      state_r  <= state_nxt;
      length_r <= length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    pos_r  <= pos_nxt;
    word_r <= word_nxt;
    data_r <= data_nxt;
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= CNT_BITS'(DEPTH))
    else $error("list count above capacity");

  a_len_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    (length_r != length_nxt) |-> res_valid)
    else $error("count changed without a result");

  a_ins_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (ptr_r >= pos_r))
    else $error("insert shift went below the insert position");

  a_ins_put: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS && ptr_r == pos_r) |=> (state_r == S_INS_PUT))
    else $error("insert did not store the new word after the shift");

  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (state_r != S_IDLE || in_accept))
    else $error("result without a request");
`endif

endmodule

// ----- design/array_list_table_unit.sv -----
// Array list table: ordered list of signed words with read, overwrite, append, insert, remove.
//
// The block keeps up to DEPTH words in one RAM with a single write port and a
// registered read, plus a count of stored words. Each request gives exactly
// one result word: data read or removed, status and new count. Insert and
// remove shift the entries from the index onward one entry per cycle through
// the RAM write port. One request is in flight at a time; a new one is taken
// when the sequencer is idle and the output register is empty or being
// drained. No clearing pass is needed after reset.
module array_list_table_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [alt_pkg::KIND_BITS-1:0]         in_kind,
  input  logic [alt_pkg::INDEX_BITS-1:0]        in_index,
  input  logic signed [alt_pkg::DATA_BITS-1:0]  in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [alt_pkg::DATA_BITS-1:0]  out_data,
  output logic [1:0]                            out_status,
  output logic [alt_pkg::COUNT_BITS-1:0]        out_count
);
  import alt_pkg::*;

  ram_req_t             ram_req;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 res_valid;
  res_t                 res;
  logic                 res_ready;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_r;

  assign res_ready = !out_valid_r || !out_stall;

  alt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_index  (in_index),
    .in_value  (in_value),
    .res_ready (res_ready),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res)
  );

  alt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // load a new word, else hold while stalled, else drop
  always_comb begin
    priority if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = signed'(out_r.data);
  assign out_status = out_r.status;
  assign out_count  = out_r.count;

endmodule

// ----- bench/array_list_table_unit_test.sv -----
// Self-checking testbench for the array list table with a queued driver and a checking monitor.
module array_list_table_unit_test;
  import alt_pkg::*;

  localparam int          LIMIT_CYCLES   = 300000;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          RANDOM_PER_RUN = 232;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [2:0]  KIND_NONE_FIRST = 3'd5;
  localparam logic [2:0]  KIND_NONE_LAST  = 3'd7;

  typedef struct {
    logic [KIND_BITS-1:0]        kind;
    logic [INDEX_BITS-1:0]       index;
    logic signed [DATA_BITS-1:0] value;
  } request_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [KIND_BITS-1:0]                 in_kind;
  logic [INDEX_BITS-1:0]                in_index;
  logic signed [DATA_BITS-1:0]          in_value;
  logic                                 out_valid;
  logic                                 out_stall;
  logic signed [DATA_BITS-1:0]          out_data;
  logic [1:0]                           out_status;
  logic [COUNT_BITS-1:0]                out_count;

  request_t pending_reqs[$];
  res_t     expected_replies[$];

  // Predicted list contents and length.
  logic signed [DATA_BITS-1:0] list_words [DEPTH];
  int                          list_len;

  // Length as seen by the stimulus generator, used to aim indexes.
  int plan_len;
  bit growing;

  int  idle_pct;
  int  stall_pct;
  bit  word_taken;
  int  fail_count;
  int  cycle_count;

  array_list_table_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_index   (in_index),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .out_status (out_status),
    .out_count  (out_count)
  );

  always #5 clk = ~clk;

  function automatic res_t apply_request(request_t req);
    res_t r;
    bit   in_range;
    int   j;
    r.data   = '0;
    r.status = ST_DONE;
    in_range = (int'(req.index) < list_len);
    case (req.kind)
      KIND_READ: begin
        if (!in_range) r.status = ST_RANGE;
        else r.data = list_words[req.index];
      end
      KIND_WRITE: begin
        if (!in_range) r.status = ST_RANGE;
        else list_words[req.index] = req.value;
      end
      KIND_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = req.value;
          list_len++;
        end
      end
      KIND_INSERT: begin
        if (!in_range) begin
          r.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // open a gap by moving later words up
          for (j = list_len; j > int'(req.index); j--) list_words[j] = list_words[j-1];
          list_words[req.index] = req.value;
          list_len++;
        end
      end
      KIND_REMOVE: begin
        if (!in_range) begin
          r.status = ST_RANGE;
        end else begin
          r.data = list_words[req.index];
          for (j = int'(req.index); j + 1 < list_len; j++) list_words[j] = list_words[j+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.count = COUNT_BITS'(list_len);
    return r;
  endfunction

  task automatic queue_req(logic [KIND_BITS-1:0] kind, logic [INDEX_BITS-1:0] index,
                           logic signed [DATA_BITS-1:0] value);
    request_t req;
    req.kind  = kind;
    req.index = index;
    req.value = value;
    pending_reqs.insert(pending_reqs.size(), req);
    case (kind)
      KIND_APPEND: if (plan_len < DEPTH) plan_len++;
      KIND_INSERT: if (int'(index) < plan_len && plan_len < DEPTH) plan_len++;
      KIND_REMOVE: if (int'(index) < plan_len) plan_len--;
      default: ;
    endcase
  endtask

  task automatic queue_random(int n);
    logic [KIND_BITS-1:0]        kind;
    logic [INDEX_BITS-1:0]       index;
    logic signed [DATA_BITS-1:0] value;
    int                          roll;
    repeat (n) begin
      // swing between filling and draining so both ends are visited
      if (plan_len == DEPTH && growing && $urandom_range(0, 99) < 30) growing = 0;
      else if (plan_len == 0 && !growing && $urandom_range(0, 99) < 30) growing = 1;
      else if ($urandom_range(0, 99) < 3) growing = !growing;
      roll = $urandom_range(0, 99);
      if (growing) begin
        if (roll < 35) kind = KIND_APPEND;
        else if (roll < 60) kind = KIND_INSERT;
        else if (roll < 73) kind = KIND_READ;
        else if (roll < 83) kind = KIND_WRITE;
        else if (roll < 95) kind = KIND_REMOVE;
        else kind = KIND_BITS'($urandom_range(KIND_NONE_FIRST, KIND_NONE_LAST));
      end else begin
        if (roll < 40) kind = KIND_REMOVE;
        else if (roll < 60) kind = KIND_READ;
        else if (roll < 75) kind = KIND_WRITE;
        else if (roll < 85) kind = KIND_APPEND;
        else if (roll < 95) kind = KIND_INSERT;
        else kind = KIND_BITS'($urandom_range(KIND_NONE_FIRST, KIND_NONE_LAST));
      end
      if (plan_len > 0 && $urandom_range(0, 99) < 85)
        index = INDEX_BITS'($urandom_range(0, plan_len - 1));
      else if (plan_len < DEPTH)
        index = INDEX_BITS'($urandom_range(plan_len, DEPTH - 1));
      else
        index = INDEX_BITS'($urandom_range(0, DEPTH - 1));
      case ($urandom_range(0, 39))
        0: value = 32'sh8000_0000;
        1: value = 32'sh7fff_ffff;
        2: value = '0;
        3: value = '1;
        default: value = $urandom;
      endcase
      queue_req(kind, index, value);
    end
  endtask

  task automatic note_failure(string what, res_t want, res_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s: expected data %0d status %0d count %0d, got data %0d status %0d count %0d",
               what, $signed(want.data), want.status, want.count,
               $signed(got.data), got.status, got.count);
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
  endtask

  // Driver: present words at the falling edge, hold them while stalled.
  always @(negedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (!in_valid || word_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_kind  <= nxt.kind;
          in_index <= nxt.index;
          in_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each accepted word, then check each accepted result.
  always @(posedge clk) begin
    request_t req;
    res_t     got;
    res_t     want;
    word_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        word_taken = 1'b1;
        req.kind   = in_kind;
        req.index  = in_index;
        req.value  = in_value;
        expected_replies.insert(expected_replies.size(), apply_request(req));
      end
      if (out_valid && !out_stall) begin
        got.data   = out_data;
        got.status = status_t'(out_status);
        got.count  = out_count;
        if (expected_replies.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) note_failure("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int k;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = '0;
    in_index    = '0;
    in_value    = '0;
    out_stall   = 1'b0;
    word_taken  = 1'b0;
    fail_count  = 0;
    cycle_count = 0;
    list_len    = 0;
    plan_len    = 0;
    growing     = 1'b1;
    idle_pct    = 0;
    stall_pct   = 0;
    for (k = 0; k < DEPTH; k++) list_words[k] = '0;

    // directed: empty list, extremes, every kind, boundaries
    queue_req(KIND_READ,   4'd0,  32'sd0);
    queue_req(KIND_WRITE,  4'd0,  32'sd1);
    queue_req(KIND_INSERT, 4'd0,  32'sd2);
    queue_req(KIND_REMOVE, 4'd0,  32'sd0);
    queue_req(KIND_APPEND, 4'd15, 32'sh8000_0000);
    queue_req(KIND_APPEND, 4'd0,  32'sh7fff_ffff);
    queue_req(KIND_APPEND, 4'd7,  32'sd0);
    queue_req(KIND_READ,   4'd0,  32'sd0);
    queue_req(KIND_READ,   4'd1,  32'sd0);
    queue_req(KIND_WRITE,  4'd1,  -32'sd1);
    queue_req(KIND_READ,   4'd1,  32'sd0);
    queue_req(KIND_INSERT, 4'd0,  32'sh5a5a_a5a5);
    queue_req(KIND_INSERT, 4'd4,  32'sd9);
    queue_req(KIND_INSERT, 4'd3,  32'sd11);
    queue_req(KIND_READ,   4'd15, 32'sd0);
    queue_req(KIND_WRITE,  4'd15, -32'sd1);
    for (k = KIND_NONE_FIRST; k <= KIND_NONE_LAST; k++)
      queue_req(KIND_BITS'(k), 4'd15, -32'sd1);
    queue_req(KIND_REMOVE, 4'd1,  32'sd0);
    queue_req(KIND_REMOVE, 4'd3,  32'sd0);
    queue_req(KIND_REMOVE, 4'd15, 32'sd0);
    queue_req(KIND_REMOVE, 4'd0,  32'sd0);
    queue_random(RANDOM_PER_RUN);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait_quiet();
    idle_pct  = 67;
    stall_pct = 0;
    queue_random(RANDOM_PER_RUN);
    wait_quiet();
    idle_pct  = 0;
    stall_pct = 67;
    queue_random(RANDOM_PER_RUN);
    wait_quiet();
    idle_pct  = 14;
    stall_pct = 14;
    queue_random(RANDOM_PER_RUN);
    wait_quiet();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_replies.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", expected_replies.size());
    end
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
design/alt_pkg.sv
design/alt_ram.sv
design/alt_ctrl.sv
design/array_list_table_unit.sv
bench/array_list_table_unit_test.sv
